### rtl/qpr_pkg.sv
// shared constants for the quaternion to pitch and roll pipeline
package qpr_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 7;
    localparam int TABLE_LEN       = 30;

    // pi in radians q.30
    localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;

    // truncated arctangent of 2^-i, radians q.30
    localparam logic signed [33:0] ATAN_TAB [0:TABLE_LEN-1] = '{
        34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158, 34'sd67021686,
        34'sd33543515,  34'sd16775850,  34'sd8388437,   34'sd4194282,   34'sd2097149,
        34'sd1048575,   34'sd524287,    34'sd262143,    34'sd131071,    34'sd65535,
        34'sd32767,     34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
        34'sd1023,      34'sd511,       34'sd255,       34'sd127,       34'sd63,
        34'sd31,        34'sd15,        34'sd7,         34'sd3,         34'sd1
    };

    // degree conversion: round(|a| * 573 / (10 * 2^CONV_SHIFT))
    localparam int          CONV_SHIFT = 30 - ANGLE_FRAC_BITS;
    localparam logic [43:0] CONV_HALF  = 44'd5 << CONV_SHIFT;
    localparam logic [9:0]  DEG_MUL    = 10'd573;
    localparam logic [31:0] RECIP_TEN  = 32'hCCCC_CCCD;
    localparam int          RECIP_SH   = 35;

    // pipeline shape
    localparam int SQRT_BITS    = 31;
    localparam int FRONT_STAGES = 4;
    localparam int LANE_STAGES  = 3 + CORDIC_STEPS + 4;
    localparam int PIPE_STAGES  = FRONT_STAGES + SQRT_BITS + LANE_STAGES;

endpackage

### rtl/qpr_cordic.sv
// vectoring cordic lane: atan2 of (y, x) to signed degree units
module qpr_cordic (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [35:0] i_y,
    input  logic signed [35:0] i_x,
    output logic signed [15:0] o_angle
);

    localparam int S = qpr_pkg::CORDIC_STEPS;

    logic signed [63:0] w_x, w_y;
    logic signed [63:0] r_x0, r_y0;
    logic signed [33:0] r_z0;
    logic               r_zf0;
    logic signed [63:0] n1_x, n1_y, n1_m, r_x1, r_y1, r_m1;
    logic signed [33:0] r_z1;
    logic               r_zf1;
    logic signed [63:0] n2_x, n2_y, n2_m;
    logic signed [63:0] r_cx [0:S];
    logic signed [63:0] r_cy [0:S];
    logic signed [33:0] r_cz [0:S];
    logic               r_czf [0:S];
    logic [33:0]        w_mag;
    logic [43:0]        r_m;
    logic [31:0]        r_q10;
    logic [63:0]        r_p;
    logic               r_neg0, r_neg1, r_neg2;
    logic [15:0]        w_q;

    assign w_x = {{28{i_x[35]}}, i_x};
    assign w_y = {{28{i_y[35]}}, i_y};

    // fold the left half plane, zero ordinate bypasses the rotations
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zf0 <= (i_y == 36'sd0);
            if (i_x < 0) begin
                r_x0 <= -w_x;
                r_y0 <= -w_y;
                if (i_y == 36'sd0)
                    r_z0 <= qpr_pkg::PI_Q30;
                else
                    r_z0 <= (i_y > 0) ? qpr_pkg::PI_Q30 : -qpr_pkg::PI_Q30;
            end else begin
                r_x0 <= w_x;
                r_y0 <= w_y;
                r_z0 <= 34'sd0;
            end
        end
    end

    // normalize, coarse shifts
    always_comb begin
        n1_x = r_x0;
        n1_y = r_y0;
        n1_m = (r_x0 < 0 ? -r_x0 : r_x0) | (r_y0 < 0 ? -r_y0 : r_y0);
        for (int j = 0; j < 3; j++) begin
            if (n1_m < (64'sd1 <<< (59 - (32 >> j)))) begin
                n1_x = n1_x <<< (32 >> j);
                n1_y = n1_y <<< (32 >> j);
                n1_m = n1_m <<< (32 >> j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1  <= n1_x;
            r_y1  <= n1_y;
            r_m1  <= n1_m;
            r_z1  <= r_z0;
            r_zf1 <= r_zf0;
        end
    end

    // normalize, fine shifts
    always_comb begin
        n2_x = r_x1;
        n2_y = r_y1;
        n2_m = r_m1;
        for (int j = 0; j < 3; j++) begin
            if (n2_m < (64'sd1 <<< (59 - (4 >> j)))) begin
                n2_x = n2_x <<< (4 >> j);
                n2_y = n2_y <<< (4 >> j);
                n2_m = n2_m <<< (4 >> j);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx[0]  <= n2_x;
            r_cy[0]  <= n2_y;
            r_cz[0]  <= r_z1;
            r_czf[0] <= r_zf1;
        end
    end

    // one rotation per stage
    for (genvar i = 0; i < S; i++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_czf[i+1] <= r_czf[i];
                if (r_cy[i] > 0) begin
                    r_cx[i+1] <= r_cx[i] + (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] - (r_cx[i] >>> i);
                    r_cz[i+1] <= r_czf[i] ? r_cz[i] : r_cz[i] + qpr_pkg::ATAN_TAB[i];
                end else begin
                    r_cx[i+1] <= r_cx[i] - (r_cy[i] >>> i);
                    r_cy[i+1] <= r_cy[i] + (r_cx[i] >>> i);
                    r_cz[i+1] <= r_czf[i] ? r_cz[i] : r_cz[i] - qpr_pkg::ATAN_TAB[i];
                end
            end
        end
    end

    // radians q.30 to rounded degree units
    assign w_mag = r_cz[S] < 0 ? 34'(-r_cz[S]) : 34'(r_cz[S]);
    assign w_q   = r_p[qpr_pkg::RECIP_SH+15:qpr_pkg::RECIP_SH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg0  <= r_cz[S] < 0;
            r_m     <= 44'(w_mag) * 44'(qpr_pkg::DEG_MUL);
            r_neg1  <= r_neg0;
            r_q10   <= 32'((r_m + qpr_pkg::CONV_HALF) >> qpr_pkg::CONV_SHIFT);
            r_neg2  <= r_neg1;
            r_p     <= 64'(r_q10) * 64'(qpr_pkg::RECIP_TEN);
            o_angle <= r_neg2 ? -$signed(w_q) : $signed(w_q);
        end
    end

endmodule

### rtl/quaternion_to_pitch_roll.sv
// top level: quaternion to pitch and roll angle pipeline
//
// takes one unit quaternion (w, x, y, z in signed q2.30) per beat and gives
// pitch = asin(2(wy - xz)) and roll = atan2(2(yz + wx), 1 - 2(x^2 + y^2)),
// both scaled by 57.3 and given in 1/128 degree units. a beat whose tuser
// flag is clear is taken and dropped, giving no result. the block is a
// fully pipelined datapath: one beat per cycle while the skid entry is
// free. a result passes through the front end, the 31-stage square root,
// the cordic stages, the degree conversion and the output register.
// the pipeline advances as a whole; a two-entry output (register plus skid)
// lets the input keep flowing after a sink stall until the skid entry fills.
module quaternion_to_pitch_roll (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [127:0] i_s_tdata,   // quat_w, quat_x, quat_y, quat_z
    input  logic         i_s_tuser,   // quat_present
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [31:0]  o_m_tdata    // pitch_angle, roll_angle, zero pad
);

    localparam int NS = qpr_pkg::PIPE_STAGES;
    localparam int SB = qpr_pkg::SQRT_BITS;

    logic w_en;
    logic r_v [0:NS-1];

    logic signed [31:0] w_qw, w_qx, w_qy, w_qz;
    logic signed [63:0] w_pwy, w_pxz, w_pyz, w_pwx, w_pxx, w_pyy;
    logic signed [33:0] r_wy, r_xz, r_yz, r_wx, r_xx, r_yy;

    logic signed [35:0] w_d2;
    logic signed [31:0] r_s1, r_s2;
    logic signed [35:0] r_ny1, r_nx1, r_ny2, r_nx2;
    logic [30:0]        w_sabs;
    logic [61:0]        r_sq;

    // square root pipeline, index 0 is the front end's last stage
    logic [61:0]        r_rem  [0:SB];
    logic [30:0]        r_root [0:SB];
    logic signed [31:0] r_s    [0:SB];
    logic signed [35:0] r_ny   [0:SB];
    logic signed [35:0] r_nx   [0:SB];

    logic signed [15:0] w_pitch, w_roll;
    logic [30:0]        w_pack;
    logic [30:0]        r_out, r_skid;
    logic               r_ov, r_skid_v, w_take, w_pv;

    // whole pipeline moves while the skid entry is free
    assign w_en       = !r_skid_v;
    assign o_s_tready = w_en;

    assign w_qw = i_s_tdata[31:0];
    assign w_qx = i_s_tdata[63:32];
    assign w_qy = i_s_tdata[95:64];
    assign w_qz = i_s_tdata[127:96];

    // valid bits ride along with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NS; k++) r_v[k] <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= i_s_tvalid & i_s_tuser;
            for (int k = 1; k < NS; k++) r_v[k] <= r_v[k-1];
        end
    end

    // stage 0: component products floored to q.30
    assign w_pwy = w_qw * w_qy;
    assign w_pxz = w_qx * w_qz;
    assign w_pyz = w_qy * w_qz;
    assign w_pwx = w_qw * w_qx;
    assign w_pxx = w_qx * w_qx;
    assign w_pyy = w_qy * w_qy;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_wy <= w_pwy[63:30];
            r_xz <= w_pxz[63:30];
            r_yz <= w_pyz[63:30];
            r_wx <= w_pwx[63:30];
            r_xx <= w_pxx[63:30];
            r_yy <= w_pyy[63:30];
        end
    end

    // stage 1: asin argument with clamp, roll vector
    // operands widened first so sums of large components do not wrap
    assign w_d2 = (36'(r_wy) - 36'(r_xz)) <<< 1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_d2 > 36'sd1073741824)
                r_s1 <= 32'sd1073741824;
            else if (w_d2 < -36'sd1073741824)
                r_s1 <= -32'sd1073741824;
            else
                r_s1 <= w_d2[31:0];
            r_ny1 <= (36'(r_yz) + 36'(r_wx)) <<< 1;
            r_nx1 <= 36'sd1073741824 - ((36'(r_xx) + 36'(r_yy)) <<< 1);
        end
    end

    // stage 2: square of the asin argument
    assign w_sabs = r_s1 < 0 ? 31'(-r_s1) : 31'(r_s1);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq  <= 62'(w_sabs) * 62'(w_sabs);
            r_s2  <= r_s1;
            r_ny2 <= r_ny1;
            r_nx2 <= r_nx1;
        end
    end

    // stage 3: radicand 1 - s^2 in q.60
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rem[0]  <= (62'd1 << 60) - r_sq;
            r_root[0] <= '0;
            r_s[0]    <= r_s2;
            r_ny[0]   <= r_ny2;
            r_nx[0]   <= r_nx2;
        end
    end

    // one root bit per stage, most significant first
    for (genvar k = 0; k < SB; k++) begin : g_sqrt
        localparam int B = SB - 1 - k;
        logic [61:0] w_inc;
        assign w_inc = ({31'd0, r_root[k]} << (B + 1)) + (62'd1 << (2 * B));
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (r_rem[k] >= w_inc) begin
                    r_rem[k+1]  <= r_rem[k] - w_inc;
                    r_root[k+1] <= r_root[k] | (31'd1 << B);
                end else begin
                    r_rem[k+1]  <= r_rem[k];
                    r_root[k+1] <= r_root[k];
                end
                r_s[k+1]  <= r_s[k];
                r_ny[k+1] <= r_ny[k];
                r_nx[k+1] <= r_nx[k];
            end
        end
    end

    // pitch = atan2(s, sqrt(1 - s^2)), roll = atan2(ny, nx)
    qpr_cordic u_pitch (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_y     ({{4{r_s[SB][31]}}, r_s[SB]}),
        .i_x     ({5'd0, r_root[SB]}),
        .o_angle (w_pitch)
    );

    qpr_cordic u_roll (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_y     (r_ny[SB]),
        .i_x     (r_nx[SB]),
        .o_angle (w_roll)
    );

    // output register and skid entry
    assign w_pv   = r_v[NS-1];
    assign w_pack = {w_roll, w_pitch[14:0]};
    assign w_take = r_ov & i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov     <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_en && w_pv) begin
            if (!r_ov || w_take) begin
                r_ov <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (w_take) begin
            if (r_skid_v)
                r_skid_v <= 1'b0;
            else
                r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_pv) begin
            if (!r_ov || w_take)
                r_out <= w_pack;
            else
                r_skid <= w_pack;
        end else if (w_take && r_skid_v) begin
            r_out <= r_skid;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {1'b0, r_out};

endmodule

### test/qpr_checker.sv
// checker: watches both streams, predicts pitch and roll, compares results
`timescale 1ns / 100ps

module qpr_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [127:0] i_s_tdata,   // quat_w, quat_x, quat_y, quat_z
    input  logic         i_s_tuser,   // quat_present
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [31:0]  i_m_tdata,   // pitch_angle, roll_angle, zero pad
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct packed {
        logic signed [14:0] pitch;
        logic signed [15:0] roll;
    } t_angles;

    t_angles angle_queue[$];
    int      fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = angle_queue.size();

    function automatic longint unsigned sqrt_floor(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    // vectoring cordic, radians q.30
    function automatic longint cordic_atan2(longint y, longint x);
        longint z, xs, ys;
        z = 0;
        if (y == 0) return x < 0 ? longint'(qpr_pkg::PI_Q30) : 0;
        if (x < 0) begin
            z = y > 0 ? longint'(qpr_pkg::PI_Q30) : -longint'(qpr_pkg::PI_Q30);
            x = -x;
            y = -y;
        end
        while (mag(x) < (64'sd1 <<< 58) && mag(y) < (64'sd1 <<< 58)) begin
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < qpr_pkg::CORDIC_STEPS && i < qpr_pkg::TABLE_LEN; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(qpr_pkg::ATAN_TAB[i]);
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(qpr_pkg::ATAN_TAB[i]);
            end
        end
        return z;
    endfunction

    // radians q.30 to degree units, half away from zero
    function automatic longint to_degree_units(longint a);
        longint unsigned den, m, q;
        den = 64'd10 << (30 - qpr_pkg::ANGLE_FRAC_BITS);
        m   = longint'(mag(a)) * 573;
        q   = (m + den / 2) / den;
        return a < 0 ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_angles predict_angles(logic [127:0] d);
        longint w, x, y, z, s, c, ny, nx;
        t_angles r;
        w = longint'(signed'(d[31:0]));
        x = longint'(signed'(d[63:32]));
        y = longint'(signed'(d[95:64]));
        z = longint'(signed'(d[127:96]));
        s = 2 * (((w * y) >>> 30) - ((x * z) >>> 30));
        if (s > (64'sd1 <<< 30)) s = 64'sd1 <<< 30;
        if (s < -(64'sd1 <<< 30)) s = -(64'sd1 <<< 30);
        c = longint'(sqrt_floor(longint'(64'sd1 <<< 60) - s * s));
        ny = 2 * (((y * z) >>> 30) + ((w * x) >>> 30));
        nx = (64'sd1 <<< 30) - 2 * (((x * x) >>> 30) + ((y * y) >>> 30));
        r.pitch = 15'(to_degree_units(cordic_atan2(s, c)));
        r.roll  = 16'(to_degree_units(cordic_atan2(ny, nx)));
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_angles want, got;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready && i_s_tuser)
                angle_queue.push_back(predict_angles(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got.pitch = i_m_tdata[14:0];
                got.roll  = i_m_tdata[30:15];
                if (angle_queue.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result beat: pitch %0d roll %0d",
                                 got.pitch, got.roll);
                end else begin
                    want = angle_queue.pop_front();
                    if (want.pitch !== got.pitch || want.roll !== got.roll
                            || i_m_tdata[31] !== 1'b0) begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: pitch exp %0d got %0d, roll exp %0d got %0d",
                                     want.pitch, got.pitch, want.roll, got.roll);
                    end
                end
            end
        end
    end

endmodule

### test/testbench.sv
// testbench top: quaternion stimulus, stream idling and verdict
`timescale 1ns / 100ps

module testbench;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;
    int           fail_count;
    int           pending;
    bit           no_idle = 1'b0;

    localparam logic [31:0] ONE    = 32'h4000_0000;
    localparam logic [31:0] NEG1   = 32'hC000_0000;
    localparam logic [31:0] MAXV   = 32'h7FFF_FFFF;
    localparam logic [31:0] MINV   = 32'h8000_0000;
    localparam logic [31:0] HALF   = 32'h2000_0000;
    localparam logic [31:0] S45    = 32'h2D41_3CCD;   // cos 45 deg in q.30

    always #4 i_clk = ~i_clk;

    quaternion_to_pitch_roll dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    qpr_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // sink stalls about 15 percent of cycles, none in the quiet stretch
    always @(posedge i_clk)
        m_tready <= no_idle || ($urandom_range(99) >= 15);

    // one beat on the input stream, with an optional short random gap first
    task automatic send_quat(input logic present, input logic [31:0] w, x, y, z);
        int gap;
        gap = (!no_idle && $urandom_range(99) < 12) ? $urandom_range(1, 2) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= present;
        s_tdata  <= {z, y, x, w};
        do @(posedge i_clk); while (!s_tready);
    endtask

    // random component: full range, near unit scale, or zero
    function automatic logic [31:0] rand_part(int kind);
        logic [31:0] v;
        v = $urandom;
        case (kind)
            0: return v;
            1: return 32'($signed(v) >>> $urandom_range(1, 9));
            default: return ($urandom_range(3) == 0) ? 32'd0 : 32'($signed(v) >>> 1);
        endcase
    endfunction

    initial begin
        int kind;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corners
        send_quat(1'b1, ONE, 0, 0, 0);          // identity
        send_quat(1'b1, 0, 0, 0, 0);            // zero quaternion
        send_quat(1'b0, ONE, ONE, ONE, ONE);    // no quaternion, dropped
        send_quat(1'b1, MAXV, MAXV, MAXV, MAXV);
        send_quat(1'b1, MINV, MINV, MINV, MINV);
        send_quat(1'b1, MAXV, MINV, MAXV, MINV);
        send_quat(1'b1, MINV, MAXV, MINV, MAXV);
        send_quat(1'b1, S45, 0, S45, 0);        // pitch +90, clamp edge
        send_quat(1'b1, S45, 0, 32'(-$signed(S45)), 0);
        send_quat(1'b1, ONE, 0, ONE, 0);        // asin argument beyond one
        send_quat(1'b1, ONE, 0, NEG1, 0);       // beyond minus one
        send_quat(1'b1, 0, 0, ONE, 0);          // zero ordinate, negative abscissa
        send_quat(1'b1, 0, ONE, 0, 0);          // roll of pi
        send_quat(1'b1, S45, S45, 0, 0);        // roll +90
        send_quat(1'b1, S45, 32'(-$signed(S45)), 0, 0);
        send_quat(1'b1, HALF, ONE, 0, HALF);    // negative abscissa, ordinate > 0
        send_quat(1'b1, HALF, NEG1, 0, HALF);   // negative abscissa, ordinate < 0
        send_quat(1'b1, 0, 0, 0, ONE);
        send_quat(1'b1, 32'd1, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
        send_quat(1'b0, 0, 0, 0, 0);
        send_quat(1'b1, HALF, HALF, HALF, HALF);

        // hold off until the pipeline has drained
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);

        for (int n = 0; n < 1850; n++) begin
            no_idle = (n >= 700 && n < 1000);
            kind = $urandom_range(9);
            if (kind == 0)
                send_quat(1'b0, $urandom, $urandom, $urandom, $urandom);
            else if (kind <= 3)
                send_quat(1'b1, rand_part(0), rand_part(0), rand_part(0), rand_part(0));
            else if (kind <= 8)
                send_quat(1'b1, rand_part(1), rand_part(1), rand_part(1), rand_part(1));
            else
                send_quat(1'b1, rand_part(2), rand_part(2), rand_part(2), rand_part(2));
        end
        s_tvalid <= 1'b0;
        no_idle = 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

### filelist.f
rtl/qpr_pkg.sv
rtl/qpr_cordic.sv
rtl/quaternion_to_pitch_roll.sv
test/qpr_checker.sv
test/testbench.sv
